FILE: rtl/core/qsa_pkg.sv
// shared types and constants for the q8.8 saturating alu
package qsa_pkg;

  localparam int DATA_W      = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;

  // operation codes as they arrive on the action port
  typedef enum logic [1:0] {
    ACT_MUL   = 2'd0,
    ACT_DIV   = 2'd1,
    ACT_ABS   = 2'd2,
    ACT_CLAMP = 2'd3
  } action_t;

  // operation class after front-end decode
  typedef enum logic [2:0] {
    KIND_MUL,
    KIND_DIV,
    KIND_DIV_ZERO,
    KIND_ABS,
    KIND_CLAMP
  } kind_t;

  // one queued operation
  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic        [DATA_W-1:0] mag_a;
    logic        [DATA_W-1:0] mag_b;
    logic                     neg;
  } op_t;

endpackage

FILE: rtl/core/qsa_front.sv
// front end: accepts a transaction and classifies it for the back end
module qsa_front import qsa_pkg::*; (
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               action,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  input  logic signed [DATA_W-1:0] operand_c,
  output logic                     push,
  output op_t                      op
);

  assign push = start && !busy;

  always_comb begin
    op.a     = operand_a;
    op.b     = operand_b;
    op.c     = operand_c;
    // magnitudes for the divider, most negative value maps to 0x8000
    op.mag_a = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : DATA_W'(operand_a);
    op.mag_b = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : DATA_W'(operand_b);
    op.neg   = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
    unique case (action_t'(action))
      ACT_MUL:   op.kind = KIND_MUL;
      ACT_DIV:   op.kind = (operand_b == '0) ? KIND_DIV_ZERO : KIND_DIV;
      ACT_ABS:   op.kind = KIND_ABS;
      ACT_CLAMP: op.kind = KIND_CLAMP;
      default:   op.kind = KIND_CLAMP;
    endcase
  end

endmodule

FILE: rtl/core/qsa_fifo.sv
// short operation queue between front end and back end
module qsa_fifo import qsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  op_in,
  output logic out_valid,
  output op_t  op_out,
  output logic full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;

  // back end takes the head whenever there is one
  assign pop       = (count != '0);
  assign out_valid = pop;
  assign op_out    = mem[rd_ptr];
  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/qsa_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module qsa_div_pipe import qsa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [DATA_W-1:0]               in_mag_a,
  input  logic [DATA_W-1:0]               in_mag_b,
  input  logic                            in_neg,
  output logic                            out_valid,
  output logic [DATA_W+FRAC_BITS-1:0]     out_quot,
  output logic                            out_neg
);

  localparam int QW = DATA_W + FRAC_BITS;

  logic              vld [QW];
  logic [DATA_W-1:0] rem [QW];
  logic [QW-1:0]     dq  [QW];
  logic [DATA_W-1:0] dvs [QW];
  logic              sgn [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              p_vld;
    logic [DATA_W-1:0] p_rem;
    logic [QW-1:0]     p_dq;
    logic [DATA_W-1:0] p_dvs;
    logic              p_sgn;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              take;

    if (k == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rem = '0;
      assign p_dq  = {in_mag_a, {FRAC_BITS{1'b0}}};
      assign p_dvs = in_mag_b;
      assign p_sgn = in_neg;
    end else begin : g_next
      assign p_vld = vld[k-1];
      assign p_rem = rem[k-1];
      assign p_dq  = dq[k-1];
      assign p_dvs = dvs[k-1];
      assign p_sgn = sgn[k-1];
    end

    // partial remainder stays below the divisor, so trial fits in DATA_W bits
    assign trial = {p_rem, p_dq[QW-1]};
    assign diff  = trial - {1'b0, p_dvs};
    assign take  = !diff[DATA_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dq[k]  <= {p_dq[QW-2:0], take};
      dvs[k] <= p_dvs;
      sgn[k] <= p_sgn;
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quot  = dq[QW-1];
  assign out_neg   = sgn[QW-1];

endmodule

FILE: rtl/core/qsa_back.sv
// back end: multiply, divide, abs and clamp with saturation, fixed latency
module qsa_back import qsa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  op_t                      in_op,
  output logic                     done,
  output logic signed [DATA_W-1:0] result
);

  localparam int QW   = DATA_W + FRAC_BITS;
  localparam int PW   = 2 * DATA_W;
  localparam int DLY  = QW - 2;

  // entry stage
  logic e_vld;
  op_t  e_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_op <= in_op;
  end

  // divide path
  logic          div_vld;
  logic [QW-1:0] div_quot;
  logic          div_neg;
  logic signed [DATA_W-1:0] div_res;

  qsa_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_vld && (e_op.kind == KIND_DIV)),
    .in_mag_a  (e_op.mag_a),
    .in_mag_b  (e_op.mag_b),
    .in_neg    (e_op.neg),
    .out_valid (div_vld),
    .out_quot  (div_quot),
    .out_neg   (div_neg)
  );

  always_comb begin
    if (div_neg) begin
      div_res = (div_quot > QW'(32768)) ? Q_MIN : -$signed(div_quot[DATA_W-1:0]);
    end else begin
      div_res = (div_quot > QW'(32767)) ? Q_MAX : $signed(div_quot[DATA_W-1:0]);
    end
  end

  // short path, stage one: product, abs, clamp, divide by zero
  logic                     s1_vld;
  kind_t                    s1_kind;
  logic signed [PW-1:0]     s1_prod;
  logic signed [DATA_W-1:0] s1_res;
  logic signed [DATA_W-1:0] s1_res_next;

  always_comb begin
    unique case (e_op.kind)
      KIND_ABS: begin
        if (e_op.a == Q_MIN) begin
          s1_res_next = Q_MAX;
        end else begin
          s1_res_next = e_op.a[DATA_W-1] ? -e_op.a : e_op.a;
        end
      end
      KIND_CLAMP: begin
        if ($signed(e_op.a) < $signed(e_op.b)) begin
          s1_res_next = e_op.b;
        end else if ($signed(e_op.a) > $signed(e_op.c)) begin
          s1_res_next = e_op.c;
        end else begin
          s1_res_next = e_op.a;
        end
      end
      KIND_DIV_ZERO: begin
        if (e_op.a == '0) begin
          s1_res_next = '0;
        end else begin
          s1_res_next = e_op.a[DATA_W-1] ? Q_MIN : Q_MAX;
        end
      end
      default: s1_res_next = e_op.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= e_vld && (e_op.kind != KIND_DIV);
    end
  end

  always_ff @(posedge clk) begin
    s1_kind <= e_op.kind;
    s1_prod <= $signed(e_op.a) * $signed(e_op.b);
    s1_res  <= s1_res_next;
  end

  // short path, stage two: floor shift and saturate the product
  logic signed [PW-1:0]     mul_sh;
  logic signed [DATA_W-1:0] mul_sat;
  logic                     s2_vld;
  logic signed [DATA_W-1:0] s2_res;

  assign mul_sh = s1_prod >>> FRAC_BITS;

  always_comb begin
    if (!mul_sh[PW-1] && (|mul_sh[PW-2:DATA_W-1])) begin
      mul_sat = Q_MAX;
    end else if (mul_sh[PW-1] && !(&mul_sh[PW-2:DATA_W-1])) begin
      mul_sat = Q_MIN;
    end else begin
      mul_sat = mul_sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_res <= (s1_kind == KIND_MUL) ? mul_sat : s1_res;
  end

  // delay line to line up with the divider output
  logic                     lane_vld [DLY];
  logic signed [DATA_W-1:0] lane_res [DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) begin
        lane_vld[i] <= 1'b0;
      end
    end else begin
      lane_vld[0] <= s2_vld;
      for (int i = 1; i < DLY; i++) begin
        lane_vld[i] <= lane_vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    lane_res[0] <= s2_res;
    for (int i = 1; i < DLY; i++) begin
      lane_res[i] <= lane_res[i-1];
    end
  end

  // output register, at most one path is valid per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_vld || lane_vld[DLY-1];
    end
  end

  always_ff @(posedge clk) begin
    result <= div_vld ? div_res : lane_res[DLY-1];
  end

endmodule

FILE: rtl/core/q8_8_saturating_alu_top.sv
// top level of the q8.8 saturating fixed-point alu
// result: an accepted transaction shows its result on done/result for one cycle,
//   after the queue, the entry register, the divider stages or the matching delay line, and the output register
// throughput: one transaction per cycle; the divider is fully pipelined at one
//   quotient bit per stage, so every operation runs through the same depth
// reset: synchronous rst clears the queue and all pipeline valids
module q8_8_saturating_alu_top import qsa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  input  logic signed [DATA_W-1:0] operand_c,
  output logic                     done,
  output logic signed [DATA_W-1:0] result
);

  // accepting edge to the edge that takes the result: queue, entry,
  // divider stages, output register, then the cycle done is held
  localparam int LATENCY = DATA_W + FRAC_BITS + 3;

  logic push;
  op_t  front_op;
  logic q_valid;
  op_t  q_op;

  // front end decodes the transaction into an operation class
  qsa_front u_front (
    .start     (start),
    .busy      (busy),
    .action    (action),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .operand_c (operand_c),
    .push      (push),
    .op        (front_op)
  );

  // queue decouples intake from execution; busy only when it is full
  qsa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .op_in     (front_op),
    .out_valid (q_valid),
    .op_out    (q_op),
    .full      (busy)
  );

  // back end executes every operation in a fixed number of cycles
  qsa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_op    (q_op),
    .done     (done),
    .result   (result)
  );

  // the back end drains one entry per cycle, so the queue never fills
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("operation queue filled up");

  // every result traces back to an earlier accepted transaction
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  // absolute value never comes out negative
  a_abs_sign: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && (action == ACT_ABS), LATENCY)) |-> !result[DATA_W-1])
    else $error("negative abs result");

  // zero divided by zero gives zero
  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && (action == ACT_DIV) && (operand_a == '0)
      && (operand_b == '0), LATENCY)) |-> (result == '0))
    else $error("zero over zero not zero");

endmodule

FILE: bench/tb_q8_8_saturating_alu_top.sv
// self-checking testbench for the q8.8 saturating fixed-point alu
module tb_q8_8_saturating_alu_top import qsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC    = 8;
  localparam int N_RAND  = 750;
  // cycles with no transaction in or out before the run is called hung;
  // a correct run is never quiet for longer than the closing tail
  localparam int HANG_LIMIT = 500;
  // settle time after the last expected result, longer than the pipeline depth
  localparam int TAIL_CYCLES = 40;

  typedef logic signed [DATA_W-1:0] q_t;

  // one directed stimulus row; known marks a result typed in by hand
  typedef struct {
    action_t act;
    q_t      a;
    q_t      b;
    q_t      c;
    bit      known;
    q_t      want;
  } stim_row_t;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  logic  [1:0] action;
  q_t    operand_a;
  q_t    operand_b;
  q_t    operand_c;
  logic  done;
  q_t    result;

  // hand-typed expectation travels alongside start so the monitor sees both
  // with the same timing
  logic  cur_known;
  q_t    cur_want;

  q_t        pending_results[$];
  stim_row_t stim_rows[$];
  int        errors;
  int        idle_cycles;
  int        op_count[4];
  int        checked;
  int        zero_div_count;

  q8_8_saturating_alu_top #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .operand_c(operand_c),
    .done(done),
    .result(result)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // clip a wide intermediate to the signed 16-bit range
  function automatic q_t sat_q(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return q_t'(v);
  endfunction

  // expected alu output for one transaction
  function automatic q_t alu_expected(action_t act, q_t a, q_t b, q_t c);
    longint wide;
    case (act)
      ACT_MUL: begin
        // arithmetic shift of the full product floors toward minus infinity
        wide = (longint'(a) * longint'(b)) >>> FRAC;
        return sat_q(wide);
      end
      ACT_DIV: begin
        // divide by zero goes to the rail matching the dividend sign, zero over zero to zero
        if (b == 0) begin
          if (a > 0) return Q_MAX;
          if (a < 0) return Q_MIN;
          return '0;
        end
        // integer division here truncates toward zero
        wide = (longint'(a) <<< FRAC) / longint'(b);
        return sat_q(wide);
      end
      ACT_ABS: begin
        if (a == Q_MIN) return Q_MAX;
        if (a < 0) return -a;
        return a;
      end
      default: begin
        // crossed bounds: a value below the lower bound gets it, any other the upper bound
        if (a < b) return b;
        if (a > c) return c;
        return a;
      end
    endcase
  endfunction

  function automatic stim_row_t mk_row(action_t act, q_t a, q_t b, q_t c,
                                       bit known, q_t want);
    stim_row_t r;
    r.act   = act;
    r.a     = a;
    r.b     = b;
    r.c     = c;
    r.known = known;
    r.want  = want;
    return r;
  endfunction

  // random operand biased toward rails, zero, unit and small values
  function automatic q_t rand_operand();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return q_t'(int'($urandom_range(0, 1023)) - 512);
      4:       return q_t'((int'($urandom_range(0, 64)) - 32) * 256);
      5:       return $urandom_range(0, 1) ? q_t'(256) : q_t'(-256);
      default: return q_t'($urandom());
    endcase
  endfunction

  // present one transaction and hold it until the alu takes it
  task automatic send_op(action_t act, q_t a, q_t b, q_t c, bit known, q_t want);
    start     <= 1'b1;
    action    <= act;
    operand_a <= a;
    operand_b <= b;
    operand_c <= c;
    cur_known <= known;
    cur_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    op_count[act]++;
    if (act == ACT_DIV && b == 0) zero_div_count++;
  endtask

  // drop start and idle for the drawn number of cycles, if it is nonzero
  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // monitor: score results first, then log the transaction taken at this edge
  always @(posedge clk) begin
    q_t got_exp;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, actual %0d", $realtime, result);
          errors++;
        end else begin
          got_exp = pending_results.pop_front();
          checked++;
          if (result !== got_exp) begin
            $display("%0t: result mismatch, expected %0d actual %0d",
                     $realtime, got_exp, result);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (cur_known)
          pending_results.push_back(cur_want);
        else
          pending_results.push_back(alu_expected(action_t'(action), operand_a,
                                                 operand_b, operand_c));
      end
    end
  end

  // watchdog on cycles with no transaction moving in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, HANG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    action_t act;
    q_t      a;
    q_t      b;
    q_t      c;
    q_t      t;
    bit      burst;
    int      gap;

    rst            = 1'b1;
    start          = 1'b0;
    action         = ACT_MUL;
    operand_a      = '0;
    operand_b      = '0;
    operand_c      = '0;
    cur_known      = 1'b0;
    cur_want       = '0;
    errors         = 0;
    checked        = 0;
    zero_div_count = 0;
    foreach (op_count[i]) op_count[i] = 0;

    // directed rows: rails, units, sign cases, divide by zero, abs of the
    // most negative value, crossed clamp bounds
    stim_rows.push_back(mk_row(ACT_MUL, Q_MAX, Q_MAX, '0, 1, Q_MAX));
    stim_rows.push_back(mk_row(ACT_MUL, Q_MIN, Q_MIN, '0, 1, Q_MAX));
    stim_rows.push_back(mk_row(ACT_MUL, Q_MIN, Q_MAX, '0, 1, Q_MIN));
    stim_rows.push_back(mk_row(ACT_MUL, 16'sd256, 16'sd256, '0, 1, 16'sd256));
    stim_rows.push_back(mk_row(ACT_MUL, '0, Q_MIN, Q_MAX, 1, '0));
    stim_rows.push_back(mk_row(ACT_MUL, -16'sd1, 16'sd1, '0, 0, '0));
    stim_rows.push_back(mk_row(ACT_MUL, -16'sd384, 16'sd171, '0, 0, '0));
    stim_rows.push_back(mk_row(ACT_DIV, 16'sd5, '0, '0, 1, Q_MAX));
    stim_rows.push_back(mk_row(ACT_DIV, -16'sd5, '0, '0, 1, Q_MIN));
    stim_rows.push_back(mk_row(ACT_DIV, '0, '0, '0, 1, '0));
    stim_rows.push_back(mk_row(ACT_DIV, 16'sd256, 16'sd256, '0, 1, 16'sd256));
    stim_rows.push_back(mk_row(ACT_DIV, Q_MIN, -16'sd1, '0, 0, '0));
    stim_rows.push_back(mk_row(ACT_DIV, 16'sd1, 16'sd3, '0, 0, '0));
    stim_rows.push_back(mk_row(ACT_DIV, -16'sd1, 16'sd3, '0, 0, '0));
    stim_rows.push_back(mk_row(ACT_DIV, Q_MAX, Q_MIN, '0, 0, '0));
    stim_rows.push_back(mk_row(ACT_ABS, Q_MIN, '0, '0, 1, Q_MAX));
    stim_rows.push_back(mk_row(ACT_ABS, Q_MAX, Q_MIN, Q_MIN, 1, Q_MAX));
    stim_rows.push_back(mk_row(ACT_ABS, -16'sd1, '0, '0, 1, 16'sd1));
    stim_rows.push_back(mk_row(ACT_ABS, '0, '0, '0, 1, '0));
    stim_rows.push_back(mk_row(ACT_CLAMP, -16'sd5, '0, 16'sd10, 1, '0));
    stim_rows.push_back(mk_row(ACT_CLAMP, 16'sd20, '0, 16'sd10, 1, 16'sd10));
    stim_rows.push_back(mk_row(ACT_CLAMP, 16'sd5, '0, 16'sd10, 1, 16'sd5));
    stim_rows.push_back(mk_row(ACT_CLAMP, 16'sd5, 16'sd10, '0, 1, 16'sd10));
    stim_rows.push_back(mk_row(ACT_CLAMP, 16'sd15, 16'sd10, '0, 1, '0));
    stim_rows.push_back(mk_row(ACT_CLAMP, Q_MIN, Q_MIN, Q_MAX, 1, Q_MIN));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, back to back with an occasional gap
    foreach (stim_rows[i]) begin
      send_op(stim_rows[i].act, stim_rows[i].a, stim_rows[i].b, stim_rows[i].c,
              stim_rows[i].known, stim_rows[i].want);
      idle_for($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0);
    end

    // let the directed results come home before going random
    drain_results();

    burst = 1'b0;
    for (int n = 0; n < N_RAND; n++) begin
      // every 40 transactions pick whether this stretch runs with no idling
      if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      // halfway through, stop and wait for the pipeline to empty
      if (n == N_RAND / 2) drain_results();

      act = action_t'($urandom_range(0, 3));
      a   = rand_operand();
      b   = rand_operand();
      c   = rand_operand();
      case (act)
        ACT_DIV: begin
          // extra weight on divide by zero with every dividend sign
          if ($urandom_range(0, 5) == 0) b = '0;
        end
        ACT_CLAMP: begin
          // mostly ordered bounds so all three outcomes are reachable
          if ($urandom_range(0, 3) != 0 && b > c) begin
            t = b;
            b = c;
            c = t;
          end
        end
        default: ;
      endcase

      send_op(act, a, b, c, 1'b0, '0);
      gap = burst ? 0 : $urandom_range(0, 12);
      idle_for(gap);
    end

    drain_results();
    // watch a little longer for any stray result
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d mul, %0d div (%0d by zero), %0d abs, %0d clamp transactions",
             op_count[ACT_MUL], op_count[ACT_DIV], zero_div_count,
             op_count[ACT_ABS], op_count[ACT_CLAMP]);
    $display("%0d results scored, %0d errors", checked, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (pending_results.size() != 0)
        $display("%0d expected results never arrived", pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/qsa_pkg.sv
rtl/core/qsa_front.sv
rtl/core/qsa_fifo.sv
rtl/core/qsa_div_pipe.sv
rtl/core/qsa_back.sv
rtl/core/q8_8_saturating_alu_top.sv
bench/tb_q8_8_saturating_alu_top.sv
